// File: sv/hufd_pkg.sv
// Shared types, codes and microcode program of the table-driven Huffman bit decoder.
package hufd_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int CODE_W            = 32;
   localparam int SYMBOL_W          = 32;
   localparam int LEN_W             = 6;

   // Longest code the accumulator can hold.
   localparam logic [LEN_W-1:0] CODE_LIMIT = 6'd32;

   // Request command codes.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_BIT   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   // Response status codes.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Register index within the CSR map (byte address bit 2).
   localparam logic REG_MAX_CODE_LENGTH = 1'b0;
   localparam logic REG_BIT_ORDER       = 1'b1;

   // Bit order codes.
   localparam logic ORDER_MSB_FIRST = 1'b0;

   typedef struct packed {
      logic                valid;
      logic [LEN_W-1:0]    length;
      logic [CODE_W-1:0]   code;
      logic [SYMBOL_W-1:0] symbol;
   } entry_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_CLR,
      OP_WRITE,
      OP_MAX_SCAN,
      OP_BIT,
      OP_MATCH_SCAN,
      OP_LIMIT,
      OP_ERR
   } op_type;

   typedef enum logic [2:0] {
      COND_TRUE,
      COND_ADDR_LAST,
      COND_SCAN_LAST,
      COND_SCAN_END,
      COND_LIMIT_ZERO
   } cond_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_COND,
      JMP_BRANCH,
      JMP_DISPATCH
   } jmp_type;

   typedef enum logic [2:0] {
      S_CLR,
      S_IDLE,
      S_WRITE,
      S_MAX_SCAN,
      S_BIT,
      S_MATCH_SCAN,
      S_LIMIT,
      S_ERR
   } step_type;

   typedef struct packed {
      op_type   op;
      logic     busy;
      jmp_type  jmp;
      cond_type cond;
      step_type target;
   } ucode_type;

   // Status flags the datapath reports to the sequencer.
   typedef struct packed {
      logic addr_last;
      logic scan_last;
      logic scan_end;
      logic limit_zero;
      logic in_range;
   } flags_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      op_type op;
      logic   accept;
   } ctrl_type;

   // Microcode program, one control word per step.
   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      w = '{op: OP_IDLE, busy: 1'b0, jmp: JMP_COND, cond: COND_TRUE, target: S_IDLE};
      case (s)
         S_CLR:        w = '{OP_CLR,        1'b1, JMP_COND,     COND_ADDR_LAST,  S_IDLE};
         S_IDLE:       w = '{OP_IDLE,       1'b0, JMP_DISPATCH, COND_TRUE,       S_IDLE};
         S_WRITE:      w = '{OP_WRITE,      1'b1, JMP_NEXT,     COND_TRUE,       S_IDLE};
         S_MAX_SCAN:   w = '{OP_MAX_SCAN,   1'b1, JMP_COND,     COND_SCAN_LAST,  S_IDLE};
         S_BIT:        w = '{OP_BIT,        1'b1, JMP_BRANCH,   COND_LIMIT_ZERO, S_ERR};
         S_MATCH_SCAN: w = '{OP_MATCH_SCAN, 1'b1, JMP_COND,     COND_SCAN_END,   S_LIMIT};
         S_LIMIT:      w = '{OP_LIMIT,      1'b1, JMP_COND,     COND_TRUE,       S_IDLE};
         S_ERR:        w = '{OP_ERR,        1'b1, JMP_COND,     COND_TRUE,       S_IDLE};
         default:      w = '{OP_IDLE,       1'b0, JMP_COND,     COND_TRUE,       S_IDLE};
      endcase
      return w;
   endfunction

   // Dispatch table: first step for each accepted command.
   function automatic step_type dispatch(input logic [1:0] cmd, input logic in_range);
      step_type s;
      case (cmd)
         CMD_WRITE: s = in_range ? S_WRITE : S_IDLE;
         CMD_BIT:   s = S_BIT;
         CMD_CLEAR: s = S_CLR;
         CMD_NOP:   s = S_IDLE;
         default:   s = S_IDLE;
      endcase
      return s;
   endfunction

endpackage

// File: sv/hufd_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
module hufd_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          command,
   input  hufd_pkg::flags_type flags,
   output hufd_pkg::ctrl_type  ctrl,
   output logic                busy
);
   import hufd_pkg::*;

   step_type  upc_ff;
   step_type  upc_in;
   ucode_type word;
   logic      cond_hit;
   logic      accept;
   step_type  upc_next;

   assign word     = ucode_rom(upc_ff);
   assign busy     = word.busy;
   assign accept   = start && !word.busy;
   assign upc_next = step_type'(3'(upc_ff) + 3'd1);

   always_comb begin
      case (word.cond)
         COND_TRUE:       cond_hit = 1'b1;
         COND_ADDR_LAST:  cond_hit = flags.addr_last;
         COND_SCAN_LAST:  cond_hit = flags.scan_last;
         COND_SCAN_END:   cond_hit = flags.scan_end;
         COND_LIMIT_ZERO: cond_hit = flags.limit_zero;
         default:         cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      case (word.jmp)
         JMP_NEXT:     upc_in = upc_next;
         JMP_COND:     upc_in = cond_hit ? word.target : upc_ff;
         JMP_BRANCH:   upc_in = cond_hit ? word.target : upc_next;
         JMP_DISPATCH: upc_in = accept ? dispatch(command, flags.in_range) : upc_ff;
         default:      upc_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_CLR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl.op     = word.op;
   assign ctrl.accept = accept;

endmodule

// File: sv/hufd_datapath.sv
// Datapath: entry memory, code accumulator, scan pipeline and response register.
module hufd_datapath #(
   parameter int TABLE_ENTRIES = hufd_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hufd_pkg::ctrl_type            ctrl,
   input  logic [7:0]                    req_entry_index,
   input  logic [hufd_pkg::CODE_W-1:0]   req_entry_code,
   input  logic [hufd_pkg::LEN_W-1:0]    req_entry_length,
   input  logic [hufd_pkg::SYMBOL_W-1:0] req_entry_symbol,
   input  logic                          req_stream_bit,
   input  logic [hufd_pkg::LEN_W-1:0]    max_code_length,
   input  logic                          bit_order,
   output hufd_pkg::flags_type           flags,
   output logic                          rsp_valid,
   output logic [hufd_pkg::SYMBOL_W-1:0] rsp_decoded_symbol,
   output logic                          rsp_status
);
   import hufd_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   entry_type mem [TABLE_ENTRIES];

   logic [IDX_W-1:0]    addr_ff, addr_in;
   entry_type           rd_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    wr_idx_ff;
   entry_type           wr_entry_ff;
   logic                bit_ff;
   logic [CODE_W-1:0]   acc_ff, acc_in;
   logic [LEN_W-1:0]    bits_ff, bits_in;
   logic [LEN_W-1:0]    largest_ff, largest_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0] rsp_sym_ff, rsp_sym_in;
   logic                rsp_status_ff, rsp_status_in;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;
   logic [LEN_W-1:0]    eff_limit;
   logic [LEN_W-1:0]    limit;
   logic                match_now;
   logic                rd_last;
   logic [CODE_W-1:0]   base_acc;
   logic [LEN_W-1:0]    base_bits;

   // Effective code length limit, clamped to the accumulator width.
   assign eff_limit = (max_code_length != '0) ? max_code_length : largest_ff;
   assign limit     = (eff_limit > CODE_LIMIT) ? CODE_LIMIT : eff_limit;

   assign rd_last   = rd_vld_ff && (rd_idx_ff == LAST_IDX);
   assign match_now = rd_vld_ff && rd_ff.valid && (rd_ff.length == bits_ff) &&
                      (rd_ff.code == acc_ff);

   assign flags.addr_last  = (addr_ff == LAST_IDX);
   assign flags.scan_last  = rd_last;
   assign flags.scan_end   = rd_last || match_now;
   assign flags.limit_zero = (limit == '0);
   assign flags.in_range   = (32'(req_entry_index) < 32'(TABLE_ENTRIES));

   // A code that already filled the accumulator starts over.
   assign base_acc  = (bits_ff >= CODE_LIMIT) ? '0 : acc_ff;
   assign base_bits = (bits_ff >= CODE_LIMIT) ? '0 : bits_ff;

   always_comb begin
      addr_in       = '0;
      rd_vld_in     = 1'b0;
      acc_in        = acc_ff;
      bits_in       = bits_ff;
      largest_in    = largest_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_sym_in    = rsp_sym_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = '0;
      case (ctrl.op)
         OP_IDLE: begin
            addr_in = '0;
         end
         OP_CLR: begin
            mem_we     = 1'b1;
            mem_waddr  = addr_ff;
            mem_wdata  = '0;
            addr_in    = addr_ff + 1'b1;
            acc_in     = '0;
            bits_in    = '0;
            largest_in = '0;
         end
         OP_WRITE: begin
            mem_we     = 1'b1;
            mem_waddr  = wr_idx_ff;
            mem_wdata  = wr_entry_ff;
            largest_in = '0;
         end
         OP_MAX_SCAN: begin
            addr_in   = addr_ff + 1'b1;
            rd_vld_in = 1'b1;
            if (rd_vld_ff && rd_ff.valid && (rd_ff.length > largest_ff)) begin
               largest_in = rd_ff.length;
            end
         end
         OP_BIT: begin
            hit_in = 1'b0;
            if (limit != '0) begin
               if (bit_order == ORDER_MSB_FIRST) begin
                  acc_in = {base_acc[CODE_W-2:0], bit_ff};
               end else begin
                  acc_in = base_acc | (CODE_W'(bit_ff) << base_bits[4:0]);
               end
               bits_in = base_bits + 1'b1;
            end
         end
         OP_MATCH_SCAN: begin
            addr_in   = addr_ff + 1'b1;
            rd_vld_in = 1'b1;
            if (match_now) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = rd_ff.symbol;
               rsp_status_in = STATUS_OK;
               acc_in        = '0;
               bits_in       = '0;
               hit_in        = 1'b1;
            end
         end
         OP_LIMIT: begin
            if (!hit_ff && (bits_ff >= limit)) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = '0;
               rsp_status_in = STATUS_ERR;
               acc_in        = '0;
               bits_in       = '0;
            end
         end
         OP_ERR: begin
            rsp_valid_in  = 1'b1;
            rsp_sym_in    = '0;
            rsp_status_in = STATUS_ERR;
            acc_in        = '0;
            bits_in       = '0;
         end
         default: begin
            addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff     <= mem[addr_ff];
      rd_idx_ff <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         wr_idx_ff          <= IDX_W'(req_entry_index);
         wr_entry_ff.valid  <= 1'b1;
         wr_entry_ff.length <= req_entry_length;
         wr_entry_ff.code   <= req_entry_code;
         wr_entry_ff.symbol <= req_entry_symbol;
         bit_ff             <= req_stream_bit;
      end
      rsp_sym_ff    <= rsp_sym_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         acc_ff       <= '0;
         bits_ff      <= '0;
         largest_ff   <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         acc_ff       <= acc_in;
         bits_ff      <= bits_in;
         largest_ff   <= largest_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decoded_symbol = rsp_sym_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// File: sv/huffman_table_bit_decoder_top.sv
// Top level of the table-driven Huffman bit decoder with its CSR block.
// Timing: a stream bit holds busy for the one-entry-per-cycle table scan, which ends at the
// first match, and its response strobes after that scan; with no length limit there is no
// scan and the bit goes straight to an error response. An unknown code errs only at the limit.
// Throughput: one request at a time; a write is busy for the store and a full rescan,
// a clear or a synchronous reset for the clearing sweep; responses are strobes that cannot be stalled.
module huffman_table_bit_decoder_top #(
   parameter int TABLE_ENTRIES = hufd_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_command,
   input  logic [7:0]                      req_entry_index,
   input  logic [hufd_pkg::CODE_W-1:0]     req_entry_code,
   input  logic [hufd_pkg::LEN_W-1:0]      req_entry_length,
   input  logic [hufd_pkg::SYMBOL_W-1:0]   req_entry_symbol,
   input  logic                            req_stream_bit,
   // Response channel.
   output logic                            rsp_valid,
   output logic [hufd_pkg::SYMBOL_W-1:0]   rsp_decoded_symbol,
   output logic                            rsp_status,
   // APB-style CSR port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hufd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hufd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hufd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import hufd_pkg::*;

   logic [LEN_W-1:0] max_code_length_ff;
   logic             bit_order_ff;
   logic             csr_write;
   flags_type        flags;
   ctrl_type         ctrl;

   // The CSR port never inserts wait states. Bit 2 of the byte address selects
   // the register; the low address bits are ignored.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_code_length_ff <= '0;
         bit_order_ff       <= 1'b0;
      end else if (csr_write) begin
         case (paddr[2])
            REG_MAX_CODE_LENGTH: max_code_length_ff <= pwdata[LEN_W-1:0];
            REG_BIT_ORDER:       bit_order_ff       <= pwdata[0];
            default:             bit_order_ff       <= bit_order_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MAX_CODE_LENGTH: prdata = CSR_DATA_W'(max_code_length_ff);
         REG_BIT_ORDER:       prdata = CSR_DATA_W'(bit_order_ff);
         default:             prdata = '0;
      endcase
   end

   // The sequencer walks the microcode program; each control word picks one
   // datapath operation and the next step, with a dispatch on the command
   // when a request is accepted in the idle step.
   hufd_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .flags   (flags),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   // The datapath owns the entry memory and scans it one entry per cycle, both
   // for matching a code and for finding the longest loaded length.
   hufd_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .req_entry_index    (req_entry_index),
      .req_entry_code     (req_entry_code),
      .req_entry_length   (req_entry_length),
      .req_entry_symbol   (req_entry_symbol),
      .req_stream_bit     (req_stream_bit),
      .max_code_length    (max_code_length_ff),
      .bit_order          (bit_order_ff),
      .flags              (flags),
      .rsp_valid          (rsp_valid),
      .rsp_decoded_symbol (rsp_decoded_symbol),
      .rsp_status         (rsp_status)
   );

endmodule

// File: sv/hufd_checker.sv
// Port-level checker for the Huffman bit decoder and its bind statement.
module hufd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [1:0]                    req_command,
   input logic                          rsp_valid,
   input logic [hufd_pkg::SYMBOL_W-1:0] rsp_decoded_symbol,
   input logic                          rsp_status
);
   import hufd_pkg::*;

   // Reset starts the table clearing sweep.
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // An error response always carries a zero symbol.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ERR) |-> rsp_decoded_symbol == '0)
      else $error("error response with nonzero symbol");

   // A request never produces a response in the very next cycle.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("response right after request acceptance");

   // Responses are single-cycle strobes.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // Stream bits and table clears always occupy the block.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_BIT || req_command == CMD_CLEAR) |=> busy)
      else $error("block not busy after bit or clear request");

endmodule

bind huffman_table_bit_decoder_top hufd_checker u_hufd_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_command        (req_command),
   .rsp_valid          (rsp_valid),
   .rsp_decoded_symbol (rsp_decoded_symbol),
   .rsp_status         (rsp_status)
);

// File: tb/tb_top.sv
// Self-checking testbench for the table-driven Huffman bit decoder, with its own decode predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hufd_pkg::*;

   localparam int ENTRIES = TABLE_ENTRIES_DEF;
   // A stream bit may scan the whole table before its response shows.
   localparam int SETTLE_CYCLES = ENTRIES + 8;
   // Longest quiet span of a correct run: the clearing pass after reset, a settle pause,
   // or a full table scan behind the longest sender gap. Taken several times over.
   localparam int WATCHDOG_LIMIT = 8 * (ENTRIES + 16);
   localparam int RANDOM_ITEMS = 750;
   localparam int PHASES = 6;
   localparam logic ORDER_LSB_FIRST = ~ORDER_MSB_FIRST;

   typedef enum logic [1:0] {
      FROM_MODEL,
      NO_RESULT,
      FIXED_RESULT
   } check_kind_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [7:0]          index;
      logic [CODE_W-1:0]   code;
      logic [LEN_W-1:0]    length;
      logic [SYMBOL_W-1:0] symbol;
      logic                stream_bit;
   } decode_request_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                status;
   } decode_result_type;

   typedef struct packed {
      decode_request_type rq;
      check_kind_type     kind;
      decode_result_type  res;
   } directed_row_type;

   // Directed requests. Results that are obvious (errors with no table, requests that
   // return nothing) are typed in; decoded symbols come from the predictor.
   localparam directed_row_type DIRECTED [20] = '{
      // A stream bit straight after reset: no entries and no maximum, so an error.
      '{'{CMD_BIT,   8'd0,   32'h0,        6'd0,  32'h0,        1'b0},
        FIXED_RESULT, '{32'h0, STATUS_ERR}},
      '{'{CMD_BIT,   8'd255, 32'hFFFFFFFF, 6'd63, 32'hFFFFFFFF, 1'b1},
        FIXED_RESULT, '{32'h0, STATUS_ERR}},
      // The spare command does nothing at all.
      '{'{CMD_NOP,   8'd255, 32'hFFFFFFFF, 6'd63, 32'hFFFFFFFF, 1'b1},
        NO_RESULT, '{32'h0, STATUS_OK}},
      '{'{CMD_WRITE, 8'd0,   32'h2,        6'd2,  32'hFFFFFFFF, 1'b0},
        NO_RESULT, '{32'h0, STATUS_OK}},
      '{'{CMD_WRITE, 8'd255, 32'hFFFFFFFF, 6'd32, 32'h0,        1'b1},
        NO_RESULT, '{32'h0, STATUS_OK}},
      '{'{CMD_WRITE, 8'd1,   32'h0,        6'd1,  32'h12345678, 1'b0},
        NO_RESULT, '{32'h0, STATUS_OK}},
      // Same code at a higher index: the lower index must win.
      '{'{CMD_WRITE, 8'd2,   32'h0,        6'd1,  32'hDEADBEEF, 1'b0},
        NO_RESULT, '{32'h0, STATUS_OK}},
      // A zero-length entry is stored but can never match.
      '{'{CMD_WRITE, 8'd3,   32'h1,        6'd0,  32'h0BADF00D, 1'b0},
        NO_RESULT, '{32'h0, STATUS_OK}},
      '{'{CMD_BIT,   8'd0,   32'h0,        6'd0,  32'h0,        1'b1},
        FROM_MODEL, '{32'h0, STATUS_OK}},
      '{'{CMD_BIT,   8'd0,   32'h0,        6'd0,  32'h0,        1'b0},
        FROM_MODEL, '{32'h0, STATUS_OK}},
      '{'{CMD_BIT,   8'd0,   32'h0,        6'd0,  32'h0,        1'b0},
        FROM_MODEL, '{32'h0, STATUS_OK}},
      // An entry longer than the code limit pushes the effective maximum past 32.
      '{'{CMD_WRITE, 8'd4,   32'h5,        6'd63, 32'h7,        1'b0},
        NO_RESULT, '{32'h0, STATUS_OK}},
      '{'{CMD_WRITE, 8'd0,   32'h1,        6'd1,  32'hA5A5A5A5, 1'b0},
        NO_RESULT, '{32'h0, STATUS_OK}},
      '{'{CMD_BIT,   8'd0,   32'h0,        6'd0,  32'h0,        1'b1},
        FROM_MODEL, '{32'h0, STATUS_OK}},
      '{'{CMD_CLEAR, 8'd0,   32'h0,        6'd0,  32'h0,        1'b0},
        NO_RESULT, '{32'h0, STATUS_OK}},
      '{'{CMD_BIT,   8'd0,   32'h0,        6'd0,  32'h0,        1'b1},
        FIXED_RESULT, '{32'h0, STATUS_ERR}},
      '{'{CMD_WRITE, 8'd7,   32'h3,        6'd2,  32'h55,       1'b0},
        NO_RESULT, '{32'h0, STATUS_OK}},
      // Overwriting the only entry shrinks the largest loaded length to one.
      '{'{CMD_WRITE, 8'd7,   32'h1,        6'd1,  32'h66,       1'b0},
        NO_RESULT, '{32'h0, STATUS_OK}},
      '{'{CMD_BIT,   8'd0,   32'h0,        6'd0,  32'h0,        1'b0},
        FIXED_RESULT, '{32'h0, STATUS_ERR}},
      '{'{CMD_BIT,   8'd0,   32'h0,        6'd0,  32'h0,        1'b1},
        FROM_MODEL, '{32'h0, STATUS_OK}}
   };

   // Register settings per phase; the last phase is drawn at random.
   localparam int unsigned PHASE_MAX [PHASES] = '{0, 32, 63, 3, 0, 0};
   localparam logic PHASE_ORDER [PHASES] = '{ORDER_MSB_FIRST, ORDER_LSB_FIRST,
      ORDER_MSB_FIRST, ORDER_LSB_FIRST, ORDER_LSB_FIRST, ORDER_MSB_FIRST};

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_command;
   logic [7:0]            req_entry_index;
   logic [CODE_W-1:0]     req_entry_code;
   logic [LEN_W-1:0]      req_entry_length;
   logic [SYMBOL_W-1:0]   req_entry_symbol;
   logic                  req_stream_bit;
   logic                  rsp_valid;
   logic [SYMBOL_W-1:0]   rsp_decoded_symbol;
   logic                  rsp_status;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   huffman_table_bit_decoder_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_entry_index    (req_entry_index),
      .req_entry_code     (req_entry_code),
      .req_entry_length   (req_entry_length),
      .req_entry_symbol   (req_entry_symbol),
      .req_stream_bit     (req_stream_bit),
      .rsp_valid          (rsp_valid),
      .rsp_decoded_symbol (rsp_decoded_symbol),
      .rsp_status         (rsp_status),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // Predictor state: the decode table, the open code and the two registers.
   logic [CODE_W-1:0]   tbl_code   [ENTRIES];
   logic [LEN_W-1:0]    tbl_length [ENTRIES];
   logic [SYMBOL_W-1:0] tbl_symbol [ENTRIES];
   bit                  tbl_valid  [ENTRIES];
   logic [CODE_W-1:0]   code_acc;
   int unsigned         bits_in_code;
   int unsigned         longest_length;
   int unsigned         cfg_max_length;
   logic                cfg_bit_order;

   // Decoded symbols and errors still owed by the block, oldest first.
   decode_result_type pending_results [$];
   int unsigned       mismatch_count = 0;
   int unsigned       sent_items = 0;
   int unsigned       idle_cycles = 0;
   bit                sender_bursty = 1'b0;

   // Prefix-free codes of the table loaded for the current phase. Bit j of stream_code
   // is the j-th stream bit to send, whatever the bit order.
   logic [CODE_W-1:0] stream_code [16];
   int unsigned       stream_len  [16];
   int unsigned       stream_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Works out what one accepted request does to the decoder and what it returns.
   task automatic model_request(input decode_request_type rq, output bit produced,
                                output decode_result_type res);
      int unsigned limit;
      bit          found;
      produced = 1'b0;
      res = '0;
      found = 1'b0;
      case (rq.command)
         CMD_WRITE: begin
            if (rq.index < ENTRIES) begin
               tbl_code[rq.index]   = rq.code;
               tbl_length[rq.index] = rq.length;
               tbl_symbol[rq.index] = rq.symbol;
               tbl_valid[rq.index]  = 1'b1;
               // An overwritten entry no longer counts toward the largest length.
               longest_length = 0;
               for (int k = 0; k < ENTRIES; k++)
                  if (tbl_valid[k] && tbl_length[k] > longest_length)
                     longest_length = tbl_length[k];
            end
         end
         CMD_CLEAR: begin
            foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
            longest_length = 0;
            code_acc = '0;
            bits_in_code = 0;
         end
         CMD_BIT: begin
            produced = 1'b1;
            limit = (cfg_max_length != 0) ? cfg_max_length : longest_length;
            if (limit > CODE_LIMIT) limit = CODE_LIMIT;
            if (limit == 0) begin
               // Nothing can ever match, so every bit is an error on its own.
               code_acc = '0;
               bits_in_code = 0;
               res = '{'0, STATUS_ERR};
            end else begin
               if (bits_in_code >= CODE_LIMIT) begin
                  code_acc = '0;
                  bits_in_code = 0;
               end
               if (cfg_bit_order == ORDER_MSB_FIRST)
                  code_acc = {code_acc[CODE_W-2:0], rq.stream_bit};
               else
                  code_acc = code_acc | (CODE_W'(rq.stream_bit) << bits_in_code);
               bits_in_code++;
               // Lowest index among the entries of exactly this length wins.
               for (int k = 0; k < ENTRIES; k++) begin
                  if (!found && tbl_valid[k] && tbl_length[k] == bits_in_code &&
                      tbl_code[k] == code_acc) begin
                     found = 1'b1;
                     res = '{tbl_symbol[k], STATUS_OK};
                  end
               end
               if (found || bits_in_code >= limit) begin
                  if (!found) res = '{'0, STATUS_ERR};
                  code_acc = '0;
                  bits_in_code = 0;
               end else begin
                  produced = 1'b0;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Presents one request, waits for the block to take it, records what it owes, and
   // then holds off for a random gap unless the sender is in a burst.
   task automatic send_request(input decode_request_type rq, input check_kind_type kind,
                               input decode_result_type typed);
      bit                produced;
      decode_result_type res;
      int unsigned       gap;
      @(negedge clock);
      start            = 1'b1;
      req_command      = rq.command;
      req_entry_index  = rq.index;
      req_entry_code   = rq.code;
      req_entry_length = rq.length;
      req_entry_symbol = rq.symbol;
      req_stream_bit   = rq.stream_bit;
      do @(posedge clock); while (busy);
      model_request(rq, produced, res);
      if (kind == FIXED_RESULT)
         pending_results = {pending_results, typed};
      else if (kind == FROM_MODEL && produced)
         pending_results = {pending_results, res};
      if (rq.command != CMD_NOP) sent_items++;
      gap = sender_bursty ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic decode_request_type random_request();
      decode_request_type rq;
      rq.command    = 2'($urandom_range(0, 3));
      rq.index      = 8'($urandom);
      rq.code       = $urandom;
      rq.length     = 6'($urandom);
      rq.symbol     = $urandom;
      rq.stream_bit = 1'($urandom);
      return rq;
   endfunction

   task automatic send_noise_bits(input int unsigned count);
      decode_request_type rq;
      repeat (count) begin
         rq = random_request();
         rq.command = CMD_BIT;
         send_request(rq, FROM_MODEL, '0);
      end
   endtask

   // Sends the first count bits of a loaded code; unused fields carry random values.
   task automatic feed_code(input int unsigned e, input int unsigned count);
      decode_request_type rq;
      for (int j = 0; j < count; j++) begin
         rq = random_request();
         rq.command = CMD_BIT;
         rq.stream_bit = stream_code[e][j];
         send_request(rq, FROM_MODEL, '0);
      end
   endtask

   // Loads a small canonical prefix-free code. Each stream position is flipped by a
   // common random mask so the stored codes cover all bit values and stay prefix-free.
   task automatic load_code_table(input int unsigned cap);
      int unsigned        lens [16];
      int unsigned        n;
      int unsigned        tmp;
      int unsigned        base;
      int unsigned        stride;
      logic [63:0]        canon;
      logic [63:0]        mask;
      decode_request_type rq;
      n = $urandom_range(2, 10);
      for (int i = 0; i < n; i++)
         lens[i] = ($urandom_range(0, 9) < 7) ? $urandom_range(1, (cap < 6) ? cap : 6)
                                              : $urandom_range(1, cap);
      for (int i = 1; i < n; i++)
         for (int j = i; j > 0 && lens[j-1] > lens[j]; j--) begin
            tmp       = lens[j];
            lens[j]   = lens[j-1];
            lens[j-1] = tmp;
         end
      mask   = {$urandom, $urandom};
      base   = $urandom_range(0, 255);
      stride = 2 * $urandom_range(0, 127) + 1;
      canon  = '0;
      stream_count = 0;
      for (int i = 0; i < n; i++) begin
         if (i != 0) canon = (canon + 1) << (lens[i] - lens[i-1]);
         if ((canon >> lens[i]) != 0) break;
         rq = random_request();
         rq.command = CMD_WRITE;
         rq.index   = 8'(base + i * stride);
         rq.length  = LEN_W'(lens[i]);
         rq.code    = '0;
         stream_code[stream_count] = '0;
         for (int j = 0; j < lens[i]; j++) begin
            stream_code[stream_count][j] = canon[lens[i]-1-j] ^ mask[j];
            if (cfg_bit_order == ORDER_MSB_FIRST)
               rq.code[lens[i]-1-j] = stream_code[stream_count][j];
            else
               rq.code[j] = stream_code[stream_count][j];
         end
         stream_len[stream_count] = lens[i];
         stream_count++;
         send_request(rq, FROM_MODEL, '0);
      end
   endtask

   // Registers are only touched with the block idle. Each write is followed by a
   // read back of the same register.
   task automatic csr_write(input logic reg_idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      readback = '0;
      for (int pass = 0; pass < 2; pass++) begin
         @(negedge clock);
         psel    = 1'b1;
         penable = 1'b0;
         pwrite  = (pass == 0);
         paddr   = {reg_idx, 2'b00};
         if (pass == 0)
            pwdata = value | ($urandom << ((reg_idx == REG_BIT_ORDER) ? 1 : LEN_W));
         else
            pwdata = $urandom;
         @(negedge clock);
         penable = 1'b1;
         do @(posedge clock); while (!pready);
         if (pass == 0) begin
            if (reg_idx == REG_MAX_CODE_LENGTH)
               cfg_max_length = value[LEN_W-1:0];
            else
               cfg_bit_order = value[0];
         end
         readback = prdata;
         @(negedge clock);
         psel    = 1'b0;
         penable = 1'b0;
         pwrite  = 1'b0;
      end
      if (reg_idx == REG_MAX_CODE_LENGTH && readback[LEN_W-1:0] !== cfg_max_length[LEN_W-1:0])
      begin
         $error("max_code_length: expected %0d, actual %0d", cfg_max_length,
                readback[LEN_W-1:0]);
         mismatch_count++;
      end
      if (reg_idx == REG_BIT_ORDER && readback[0] !== cfg_bit_order) begin
         $error("bit_order: expected %0d, actual %0d", cfg_bit_order, readback[0]);
         mismatch_count++;
      end
   endtask

   // Drops start, waits for every owed response, then lets a full table scan go by
   // in case a stream bit that returns nothing is still being worked on.
   task automatic drain_and_settle();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response checker: every strobe must match the oldest owed result.
   always @(posedge clock) begin
      decode_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: decoded_symbol %h, status %0d",
                   rsp_decoded_symbol, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_decoded_symbol !== want.symbol) begin
               $error("decoded_symbol: expected %h, actual %h", want.symbol,
                      rsp_decoded_symbol);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: any accepted request, response or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned phase_max;
      logic        phase_order;
      int unsigned cap;
      int unsigned pick;
      int unsigned phase_target;
      int unsigned last;

      reset            = 1'b1;
      start            = 1'b0;
      req_command      = CMD_NOP;
      req_entry_index  = '0;
      req_entry_code   = '0;
      req_entry_length = '0;
      req_entry_symbol = '0;
      req_stream_bit   = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
      code_acc       = '0;
      bits_in_code   = 0;
      longest_length = 0;
      cfg_max_length = 0;
      cfg_bit_order  = ORDER_MSB_FIRST;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed part, with the register values left by reset. The first request
      // also waits out the clearing pass that follows reset.
      foreach (DIRECTED[i]) send_request(DIRECTED[i].rq, DIRECTED[i].kind, DIRECTED[i].res);

      // Random part: each phase sets the registers, loads a fresh code and then sends
      // mostly whole codewords, with noise bits, spare commands, stray writes and
      // clears mixed in.
      for (int p = 0; p < PHASES; p++) begin
         phase_max   = (p == PHASES - 1) ? $urandom_range(1, 32) : PHASE_MAX[p];
         phase_order = (p == PHASES - 1) ? 1'($urandom) : PHASE_ORDER[p];
         if (phase_max == 0 || phase_max >= CODE_LIMIT)
            cap = CODE_LIMIT;
         else
            cap = (phase_max + 2 > CODE_LIMIT) ? CODE_LIMIT : phase_max + 2;

         drain_and_settle();
         csr_write(REG_MAX_CODE_LENGTH, phase_max);
         csr_write(REG_BIT_ORDER, phase_order);

         // The previous phase left a code open: these bits run into the new maximum.
         send_noise_bits(2);
         send_request('{CMD_CLEAR, 8'd0, 32'h0, 6'd0, 32'h0, 1'b0}, FROM_MODEL, '0);
         load_code_table(cap);

         phase_target = sent_items + RANDOM_ITEMS / PHASES;
         while (sent_items < phase_target) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) sender_bursty = !sender_bursty;
            if (pick < 78) begin
               feed_code($urandom_range(0, stream_count - 1), 0);
               last = $urandom_range(0, stream_count - 1);
               feed_code(last, stream_len[last]);
            end else if (pick < 88) begin
               send_noise_bits($urandom_range(1, 3));
            end else if (pick < 94) begin
               send_request(random_request(), FROM_MODEL, '0);
            end else if (pick < 97) begin
               send_request('{CMD_CLEAR, 8'd0, 32'h0, 6'd0, 32'h0, 1'b0}, FROM_MODEL, '0);
               load_code_table(cap);
            end else begin
               // A broken codeword: part of a code followed by random bits.
               last = $urandom_range(0, stream_count - 1);
               feed_code(last, $urandom_range(0, stream_len[last]));
               send_noise_bits(1);
            end
         end

         // Leave the longest code one bit short for the next register setting.
         last = stream_count - 1;
         if (stream_len[last] > 1) feed_code(last, stream_len[last] - 1);
         sender_bursty = 1'b0;
      end

      drain_and_settle();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
